[hw/rtl/assert_macros.svh]
// Assertion macros used by the RTL files; the top level includes them.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[hw/rtl/tlfc_pkg.sv]
// Types, codes and helpers for the LED flash controller.
// No dependencies.
package tlfc_pkg;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_ON    = 2'd1;
  localparam logic [1:0] CMD_OFF   = 2'd2;
  localparam logic [1:0] CMD_FLASH = 2'd3;

  localparam logic [1:0] RATE_FAST   = 2'd0;
  localparam logic [1:0] RATE_MIDDLE = 2'd1;
  localparam logic [1:0] RATE_SLOW   = 2'd2;

  localparam logic [2:0] MODE_OFF    = 3'd0;
  localparam logic [2:0] MODE_ON     = 3'd1;
  localparam logic [2:0] MODE_FAST   = 3'd2;
  localparam logic [2:0] MODE_MIDDLE = 3'd3;
  localparam logic [2:0] MODE_SLOW   = 3'd4;

  localparam logic [1:0] CFG_MS_PER_STEP    = 2'd0;
  localparam logic [1:0] CFG_FAST_DIVIDER   = 2'd1;
  localparam logic [1:0] CFG_MIDDLE_DIVIDER = 2'd2;
  localparam logic [1:0] CFG_SLOW_DIVIDER   = 2'd3;

  localparam logic [7:0]  RST_MS_PER_STEP    = 8'd50;
  localparam logic [7:0]  RST_FAST_DIVIDER   = 8'd1;
  localparam logic [7:0]  RST_MIDDLE_DIVIDER = 8'd5;
  localparam logic [7:0]  RST_SLOW_DIVIDER   = 8'd20;

  localparam logic [15:0] MAX_DURATION = 16'd65000;
  localparam logic [16:0] ELAPSED_MAX  = 17'h1FFFF;

  typedef struct packed {
    logic [7:0] ms_per_step;
    logic [7:0] fast_divider;
    logic [7:0] middle_divider;
    logic [7:0] slow_divider;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic        channel;
    logic [1:0]  rate;
    logic [15:0] duration_ms;
  } item_t;

  typedef struct packed {
    logic       local_pin;
    logic       global_pin;
    logic [2:0] local_mode;
    logic [2:0] global_mode;
  } result_t;

  function automatic logic is_flash(input logic [2:0] mode);
    return (mode == MODE_FAST) || (mode == MODE_MIDDLE) || (mode == MODE_SLOW);
  endfunction

endpackage

[hw/rtl/timed_led_flash_controller.sv]
// Top level of the two-channel LED flash controller: input word register,
// update core and result register. Depends on tlfc_pkg, tlfc_cfg, tlfc_core, assert_macros.svh.
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall | in_command, in_channel, in_rate, in_duration_ms
//   out     | out_valid/out_stall | out_local_pin, out_global_pin, out_*_mode
//   cfg     | cfg_we              | cfg_index, cfg_data
//
// One word per cycle sustained while out_stall is low; an accepted input word
// passes through the input register and then the result register to the out
// port. Synchronous active-low reset; no clearing pass, ready right after reset.
// out_stall holds the result register; the input register still takes one
// more word, then in_stall rises until the result moves on.
`include "assert_macros.svh"
module timed_led_flash_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic        in_channel,
  input  logic [1:0]  in_rate,
  input  logic [15:0] in_duration_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_local_pin,
  output logic        out_global_pin,
  output logic [2:0]  out_local_mode,
  output logic [2:0]  out_global_mode,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  tlfc_pkg::cfg_t    cfg;
  tlfc_pkg::item_t   item_r;
  tlfc_pkg::result_t result_nxt;
  tlfc_pkg::result_t result_r;
  logic              hold_valid_r;
  logic              out_valid_r;
  logic              advance;
  logic              take;

  assign advance  = hold_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = hold_valid_r && !advance;
  assign take     = in_valid && !in_stall;

  tlfc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tlfc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (advance),
    .item       (item_r),
    .cfg        (cfg),
    .result_nxt (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= take || in_stall;
      out_valid_r  <= advance || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.command     <= in_command;
      item_r.channel     <= in_channel;
      item_r.rate        <= in_rate;
      item_r.duration_ms <= in_duration_ms;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_local_pin   = result_r.local_pin;
  assign out_global_pin  = result_r.global_pin;
  assign out_local_mode  = result_r.local_mode;
  assign out_global_mode = result_r.global_mode;

  `ASSERT_IMPLIES(a_stall_needs_word, clk, rst_n, in_stall, hold_valid_r && out_valid_r)
  `ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_r)
  `ASSERT_NEXT(a_drain_empties_out, clk, rst_n, out_valid_r && !out_stall && !advance, !out_valid_r)

endmodule

[hw/rtl/tlfc_cfg.sv]
// Configuration register file: step period and the three flash dividers.
// Depends on tlfc_pkg.
module tlfc_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output tlfc_pkg::cfg_t    cfg
);

  tlfc_pkg::cfg_t cfg_r;
  tlfc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        tlfc_pkg::CFG_MS_PER_STEP:    cfg_nxt.ms_per_step    = cfg_data;
        tlfc_pkg::CFG_FAST_DIVIDER:   cfg_nxt.fast_divider   = cfg_data;
        tlfc_pkg::CFG_MIDDLE_DIVIDER: cfg_nxt.middle_divider = cfg_data;
        tlfc_pkg::CFG_SLOW_DIVIDER:   cfg_nxt.slow_divider   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ms_per_step    <= tlfc_pkg::RST_MS_PER_STEP;
      cfg_r.fast_divider   <= tlfc_pkg::RST_FAST_DIVIDER;
      cfg_r.middle_divider <= tlfc_pkg::RST_MIDDLE_DIVIDER;
      cfg_r.slow_divider   <= tlfc_pkg::RST_SLOW_DIVIDER;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/tlfc_core.sv]
// LED state and update logic: prescaler, rate counters, per-channel mode,
// flash timing and pin levels. Depends on tlfc_pkg.
module tlfc_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               commit,
  input  tlfc_pkg::item_t    item,
  input  tlfc_pkg::cfg_t     cfg,
  output tlfc_pkg::result_t  result_nxt
);

  logic [7:0]  prescale_r, prescale_nxt;
  logic [7:0]  fast_cnt_r, fast_cnt_nxt;
  logic [7:0]  middle_cnt_r, middle_cnt_nxt;
  logic [7:0]  slow_cnt_r, slow_cnt_nxt;
  logic [2:0]  mode_r [2];
  logic [2:0]  mode_nxt [2];
  logic        saved_r [2];
  logic        saved_nxt [2];
  logic        phase_r [2];
  logic        phase_nxt [2];
  logic        pin_r [2];
  logic        pin_nxt [2];
  logic [16:0] elapsed_r [2];
  logic [16:0] elapsed_nxt [2];
  logic [15:0] length_r [2];
  logic [15:0] length_nxt [2];

  logic [7:0] prescale_inc, fast_inc, middle_inc, slow_inc;
  logic       step, fast_wrap, middle_wrap, slow_wrap;

  assign prescale_inc = prescale_r + 8'd1;
  assign fast_inc     = fast_cnt_r + 8'd1;
  assign middle_inc   = middle_cnt_r + 8'd1;
  assign slow_inc     = slow_cnt_r + 8'd1;
  assign step         = (prescale_inc == cfg.ms_per_step);
  assign fast_wrap    = step && (fast_inc == cfg.fast_divider);
  assign middle_wrap  = step && (middle_inc == cfg.middle_divider);
  assign slow_wrap    = step && (slow_inc == cfg.slow_divider);

  always_comb begin
    prescale_nxt   = prescale_r;
    fast_cnt_nxt   = fast_cnt_r;
    middle_cnt_nxt = middle_cnt_r;
    slow_cnt_nxt   = slow_cnt_r;
    for (int c = 0; c < 2; c++) begin
      mode_nxt[c]    = mode_r[c];
      saved_nxt[c]   = saved_r[c];
      phase_nxt[c]   = phase_r[c];
      pin_nxt[c]     = pin_r[c];
      elapsed_nxt[c] = elapsed_r[c];
      length_nxt[c]  = length_r[c];
    end
    case (item.command)
      tlfc_pkg::CMD_TICK: begin
        for (int c = 0; c < 2; c++) begin
          if (elapsed_r[c] != tlfc_pkg::ELAPSED_MAX) begin
            elapsed_nxt[c] = elapsed_r[c] + 17'd1;
          end
          if (tlfc_pkg::is_flash(mode_r[c]) && (elapsed_nxt[c] > {1'b0, length_r[c]})) begin
            mode_nxt[c] = saved_r[c] ? tlfc_pkg::MODE_ON : tlfc_pkg::MODE_OFF;
          end
        end
        prescale_nxt = step ? 8'd0 : prescale_inc;
        if (step) begin
          fast_cnt_nxt   = fast_wrap ? 8'd0 : fast_inc;
          middle_cnt_nxt = middle_wrap ? 8'd0 : middle_inc;
          slow_cnt_nxt   = slow_wrap ? 8'd0 : slow_inc;
          for (int c = 0; c < 2; c++) begin
            if ((fast_wrap && (mode_nxt[c] == tlfc_pkg::MODE_FAST)) ||
                (middle_wrap && (mode_nxt[c] == tlfc_pkg::MODE_MIDDLE)) ||
                (slow_wrap && (mode_nxt[c] == tlfc_pkg::MODE_SLOW))) begin
              phase_nxt[c] = ~phase_r[c];
              pin_nxt[c]   = ~phase_r[c];
            end
            if (mode_nxt[c] == tlfc_pkg::MODE_ON) begin
              pin_nxt[c] = 1'b1;
            end else if (mode_nxt[c] == tlfc_pkg::MODE_OFF) begin
              pin_nxt[c] = 1'b0;
            end
          end
        end
      end
      tlfc_pkg::CMD_ON: begin
        mode_nxt[item.channel] = tlfc_pkg::MODE_ON;
      end
      tlfc_pkg::CMD_OFF: begin
        mode_nxt[item.channel] = tlfc_pkg::MODE_OFF;
      end
      tlfc_pkg::CMD_FLASH: begin
        if ((item.duration_ms <= tlfc_pkg::MAX_DURATION) &&
            (item.rate inside {tlfc_pkg::RATE_FAST, tlfc_pkg::RATE_MIDDLE,
                               tlfc_pkg::RATE_SLOW}) &&
            (mode_r[item.channel] inside {tlfc_pkg::MODE_ON, tlfc_pkg::MODE_OFF})) begin
          saved_nxt[item.channel]   = (mode_r[item.channel] == tlfc_pkg::MODE_ON);
          length_nxt[item.channel]  = item.duration_ms;
          elapsed_nxt[item.channel] = 17'd0;
          mode_nxt[item.channel]    = tlfc_pkg::MODE_FAST + {1'b0, item.rate};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r   <= 8'd0;
      fast_cnt_r   <= 8'd0;
      middle_cnt_r <= 8'd0;
      slow_cnt_r   <= 8'd0;
      for (int c = 0; c < 2; c++) begin
        mode_r[c]    <= tlfc_pkg::MODE_OFF;
        saved_r[c]   <= 1'b0;
        phase_r[c]   <= 1'b0;
        pin_r[c]     <= 1'b0;
        elapsed_r[c] <= 17'd0;
        length_r[c]  <= 16'd0;
      end
    end else if (commit) begin
      prescale_r   <= prescale_nxt;
      fast_cnt_r   <= fast_cnt_nxt;
      middle_cnt_r <= middle_cnt_nxt;
      slow_cnt_r   <= slow_cnt_nxt;
      for (int c = 0; c < 2; c++) begin
        mode_r[c]    <= mode_nxt[c];
        saved_r[c]   <= saved_nxt[c];
        phase_r[c]   <= phase_nxt[c];
        pin_r[c]     <= pin_nxt[c];
        elapsed_r[c] <= elapsed_nxt[c];
        length_r[c]  <= length_nxt[c];
      end
    end
  end

  assign result_nxt.local_pin   = pin_nxt[0];
  assign result_nxt.global_pin  = pin_nxt[1];
  assign result_nxt.local_mode  = mode_nxt[0];
  assign result_nxt.global_mode = mode_nxt[1];

endmodule
